>>> hdl/rcw_pkg.sv
package rcw_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int MAP_INDEX_BITS = 8;

  localparam int POS_W   = 24;
  localparam int CELL_W  = 8;
  localparam int DIR_W   = 18;
  localparam int WIN_W   = 12;
  localparam int TEX_W   = 11;
  localparam int LH_W    = 16;
  localparam int ROW_W   = 12;
  localparam int COL_W   = 10;
  localparam int STEP_W  = 26;
  localparam int START_W = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int POS_USED_W = FRAC_BITS + MAP_INDEX_BITS;
  localparam int N_W        = POS_USED_W + 2;
  localparam int NMAG_W     = POS_USED_W + 1;
  localparam int HD_W       = WIN_W + DIR_W - 1;
  localparam int NE_W       = NMAG_W + DIR_W - 1;
  localparam int DIV_LEN    = (NE_W > HD_W) ? NE_W : HD_W;
  localparam int TNUM_W     = TEX_W + FRAC_BITS;
  localparam int OFF_W      = LH_W - 1;

  localparam logic [N_W-1:0]   ONE_FP  = N_W'(2 ** FRAC_BITS);
  localparam logic [LH_W-1:0]  LH_MAX  = '1;
  localparam logic [COL_W-1:0] COL_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_ROWS    = 2'd0,
    REG_TEXTURE_WIDTH  = 2'd1,
    REG_TEXTURE_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                 d_zero;
    logic                 d_neg;
    logic                 n_zero;
    logic                 n_neg;
    logic                 side;
    logic [FRAC_BITS-1:0] other_frac;
  } geom_t;

  typedef struct packed {
    logic                 visible;
    logic [LH_W-1:0]      wall_rows;
    logic [ROW_W-1:0]     row_first;
    logic [ROW_W-1:0]     row_last;
    logic [OFF_W-1:0]     offset;
    logic [FRAC_BITS-1:0] frac;
    logic                 mirror;
  } span_t;

  typedef struct packed {
    logic               visible;
    logic [LH_W-1:0]    wall_rows;
    logic [ROW_W-1:0]   row_first;
    logic [ROW_W-1:0]   row_last;
    logic [COL_W-1:0]   texture_column;
    logic [STEP_W-1:0]  texture_step;
    logic [START_W-1:0] texture_start;
  } result_t;

endpackage

>>> hdl/rcw_if.sv
interface rcw_hit_if;
  import rcw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [POS_W-1:0]        player_x;
  logic [POS_W-1:0]        player_y;
  logic [CELL_W-1:0]       cell_x;
  logic [CELL_W-1:0]       cell_y;
  logic                    step_x_negative;
  logic                    step_y_negative;
  logic signed [DIR_W-1:0] ray_dir_x;
  logic signed [DIR_W-1:0] ray_dir_y;
  logic                    hit_side;
  modport source (output valid, player_x, player_y, cell_x, cell_y, step_x_negative,
                  step_y_negative, ray_dir_x, ray_dir_y, hit_side, input ready);
  modport sink (input valid, player_x, player_y, cell_x, cell_y, step_x_negative,
                step_y_negative, ray_dir_x, ray_dir_y, hit_side, output ready);
endinterface

interface rcw_column_if;
  import rcw_pkg::*;
  logic               valid;
  logic               ready;
  logic               visible;
  logic [LH_W-1:0]    wall_rows;
  logic [ROW_W-1:0]   row_first;
  logic [ROW_W-1:0]   row_last;
  logic [COL_W-1:0]   texture_column;
  logic [STEP_W-1:0]  texture_step;
  logic [START_W-1:0] texture_start;
  modport source (output valid, visible, wall_rows, row_first, row_last, texture_column,
                  texture_step, texture_start, input ready);
  modport sink (input valid, visible, wall_rows, row_first, row_last, texture_column,
                texture_step, texture_start, output ready);
endinterface

interface rcw_cfg_if;
  import rcw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/raycast_wall_column_setup.sv
// Wall column setup for a ray caster: one hit request in, one column request out.
// A new request can be taken every cycle unless the pipeline stalls because the
// output buffer is full. The core of the block is three radix-2 divider pipelines,
// one quotient bit per stage: two of 42 stages produce the line height and the wall
// hit fraction side by side, then one of 27 stages produces the texture step.
// A two-entry output buffer lets one more request finish while a result waits.
// Configuration writes are taken at any time and must only be issued while no
// request is in flight.
module raycast_wall_column_setup (
  input logic          clk,
  input logic          rst,
  rcw_hit_if.sink      hit,
  rcw_column_if.source column,
  rcw_cfg_if.sink      cfg
);
  import rcw_pkg::*;

  logic [WIN_W-1:0] screen_rows;
  logic [TEX_W-1:0] texture_width;
  logic [TEX_W-1:0] texture_height;
  logic             en;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_rows    <= WIN_W'(480);
      texture_width  <= TEX_W'(64);
      texture_height <= TEX_W'(64);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_SCREEN_ROWS:    screen_rows    <= cfg.data[WIN_W-1:0];
        REG_TEXTURE_WIDTH:  texture_width  <= cfg.data[TEX_W-1:0];
        REG_TEXTURE_HEIGHT: texture_height <= cfg.data[TEX_W-1:0];
        default: ;
      endcase
    end
  end

  logic [POS_USED_W-1:0]     px, py;
  logic [MAP_INDEX_BITS-1:0] cx, cy;
  logic [N_W-1:0]            nx, ny;
  logic [DIR_W-1:0]          d_sel, e_sel;

  assign px    = hit.player_x[POS_USED_W-1:0];
  assign py    = hit.player_y[POS_USED_W-1:0];
  assign cx    = hit.cell_x[MAP_INDEX_BITS-1:0];
  assign cy    = hit.cell_y[MAP_INDEX_BITS-1:0];
  assign nx    = {2'b00, cx, {FRAC_BITS{1'b0}}} - {2'b00, px}
               + (hit.step_x_negative ? ONE_FP : '0);
  assign ny    = {2'b00, cy, {FRAC_BITS{1'b0}}} - {2'b00, py}
               + (hit.step_y_negative ? ONE_FP : '0);
  assign d_sel = hit.hit_side ? hit.ray_dir_y : hit.ray_dir_x;
  assign e_sel = hit.hit_side ? hit.ray_dir_x : hit.ray_dir_y;

  logic                 v1;
  logic [N_W-1:0]       n1;
  logic [DIR_W-1:0]     d_mag1, e_mag1;
  logic                 d_neg1, d_zero1, e_neg1, side1;
  logic [FRAC_BITS-1:0] other1;

  always_ff @(posedge clk) begin
    if (en) begin
      n1      <= hit.hit_side ? ny : nx;
      d_mag1  <= d_sel[DIR_W-1] ? (~d_sel + 1'b1) : d_sel;
      d_neg1  <= d_sel[DIR_W-1];
      d_zero1 <= d_sel == '0;
      e_mag1  <= e_sel[DIR_W-1] ? (~e_sel + 1'b1) : e_sel;
      e_neg1  <= e_sel[DIR_W-1];
      side1   <= hit.hit_side;
      other1  <= hit.hit_side ? px[FRAC_BITS-1:0] : py[FRAC_BITS-1:0];
    end
  end

  logic                   v2;
  logic [NMAG_W-1:0]      n_mag2;
  logic [HD_W-1:0]        hd_mag2;
  logic [DIR_W-1:0]       d_mag2, e_mag2;
  logic                   n_neg2, n_zero2, d_neg2, d_zero2, ne_neg2, side2;
  logic [FRAC_BITS-1:0]   other2;
  logic [WIN_W+DIR_W-1:0] hd_prod;

  assign hd_prod = screen_rows * d_mag1;

  always_ff @(posedge clk) begin
    if (en) begin
      n_mag2  <= n1[N_W-1] ? NMAG_W'(~n1 + 1'b1) : NMAG_W'(n1);
      n_neg2  <= n1[N_W-1];
      n_zero2 <= n1 == '0;
      hd_mag2 <= hd_prod[HD_W-1:0];
      d_mag2  <= d_mag1;
      d_neg2  <= d_neg1;
      d_zero2 <= d_zero1;
      e_mag2  <= e_mag1;
      ne_neg2 <= n1[N_W-1] ^ e_neg1;
      side2   <= side1;
      other2  <= other1;
    end
  end

  logic                    v3;
  logic [NE_W-1:0]         ne_mag3;
  logic [HD_W-1:0]         hd_mag3;
  logic [NMAG_W-1:0]       n_mag3;
  logic [DIR_W-1:0]        d_mag3;
  logic                    ne_neg3;
  geom_t                   geom3;
  logic [NMAG_W+DIR_W-1:0] ne_prod;

  assign ne_prod = n_mag2 * e_mag2;

  always_ff @(posedge clk) begin
    if (en) begin
      ne_mag3          <= ne_prod[NE_W-1:0];
      hd_mag3          <= hd_mag2;
      n_mag3           <= n_mag2;
      d_mag3           <= d_mag2;
      ne_neg3          <= ne_neg2;
      geom3.d_zero     <= d_zero2;
      geom3.d_neg      <= d_neg2;
      geom3.n_zero     <= n_zero2;
      geom3.n_neg      <= n_neg2;
      geom3.side       <= side2;
      geom3.other_frac <= other2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= hit.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  logic               va;
  logic [DIV_LEN-1:0] qa;
  geom_t              geom_a;
  logic [NE_W-1:0]    qb;
  logic [DIR_W-1:0]   rb;
  logic               negb;

  rcw_divider #(
    .NUM_W  (DIV_LEN),
    .DEN_W  (NMAG_W),
    .SIDE_W ($bits(geom_t))
  ) u_div_height (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .num       (DIV_LEN'(hd_mag3)),
    .den       (n_mag3),
    .side_in   (geom3),
    .out_valid (va),
    .quo       (qa),
    .rem       (),
    .side_out  (geom_a)
  );

  rcw_divider #(
    .NUM_W  (NE_W),
    .DEN_W  (DIR_W),
    .SIDE_W (1)
  ) u_div_hit (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .num       (ne_mag3),
    .den       (d_mag3),
    .side_in   (ne_neg3),
    .out_valid (),
    .quo       (qb),
    .rem       (rb),
    .side_out  (negb)
  );

  logic [LH_W-1:0]      lh_a;
  logic [LH_W-2:0]      lh_half;
  logic [WIN_W-2:0]     h_half;
  logic [LH_W-1:0]      de_sum;
  logic                 vis_a;
  logic                 tall;
  logic [FRAC_BITS-1:0] q_low;
  span_t                span_next;

  assign lh_a    = geom_a.n_zero ? LH_MAX
                 : (|qa[DIV_LEN-1:LH_W]) ? LH_MAX : qa[LH_W-1:0];
  assign vis_a   = !geom_a.d_zero && (geom_a.n_zero ? !geom_a.d_neg
                 : ((geom_a.d_neg == geom_a.n_neg) && (qa != '0)));
  assign lh_half = lh_a[LH_W-1:1];
  assign h_half  = screen_rows[WIN_W-1:1];
  assign tall    = lh_half > OFF_W'(h_half);
  assign de_sum  = LH_W'(lh_half) + LH_W'(h_half);
  assign q_low   = (negb ^ geom_a.d_neg) ? (~qb[FRAC_BITS-1:0] + FRAC_BITS'(rb == '0))
                 : qb[FRAC_BITS-1:0];

  always_comb begin
    span_next.visible   = vis_a;
    span_next.wall_rows = lh_a;
    span_next.row_first = tall ? '0 : ROW_W'(OFF_W'(h_half) - lh_half);
    if (de_sum >= LH_W'(screen_rows)) begin
      span_next.row_last = (screen_rows != '0) ? screen_rows - 1'b1 : '0;
    end else begin
      span_next.row_last = de_sum[ROW_W-1:0];
    end
    span_next.offset = tall ? lh_half - OFF_W'(h_half) : '0;
    span_next.frac   = geom_a.other_frac + q_low;
    span_next.mirror = geom_a.side ? (!geom_a.d_neg && !geom_a.d_zero) : geom_a.d_neg;
  end

  logic  v4;
  span_t span4;

  always_ff @(posedge clk) begin
    if (en) begin
      span4 <= span_next;
    end
  end

  logic              vc;
  logic [TNUM_W-1:0] step_q;
  span_t             span_c;

  rcw_divider #(
    .NUM_W  (TNUM_W),
    .DEN_W  (LH_W),
    .SIDE_W ($bits(span_t))
  ) u_div_step (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .num       ({texture_height, {FRAC_BITS{1'b0}}}),
    .den       (span4.visible ? span4.wall_rows : LH_W'(1)),
    .side_in   (span4),
    .out_valid (vc),
    .quo       (step_q),
    .rem       (),
    .side_out  (span_c)
  );

  logic [FRAC_BITS+TEX_W-1:0] col_prod;
  logic [OFF_W+TNUM_W-1:0]    start_prod;
  logic                       v5;
  span_t                      span5;
  logic [TNUM_W-1:0]          step5;
  logic [FRAC_BITS+TEX_W-1:0] col_prod5;
  logic [OFF_W+TNUM_W-1:0]    start_prod5;

  assign col_prod   = span_c.frac * texture_width;
  assign start_prod = span_c.offset * step_q;

  always_ff @(posedge clk) begin
    if (en) begin
      span5       <= span_c;
      step5       <= step_q;
      col_prod5   <= col_prod;
      start_prod5 <= start_prod;
    end
  end

  logic [TEX_W-1:0] col_raw;
  logic [TEX_W-1:0] col_mir;
  result_t          res_next;
  logic             v6;
  result_t          res6;

  assign col_raw = col_prod5[FRAC_BITS +: TEX_W];
  assign col_mir = span5.mirror ? texture_width - TEX_W'(1) - col_raw : col_raw;

  always_comb begin
    res_next = '0;
    if (span5.visible) begin
      res_next.visible   = 1'b1;
      res_next.wall_rows = span5.wall_rows;
      res_next.row_first = span5.row_first;
      res_next.row_last  = span5.row_last;
      if (texture_width == '0) begin
        res_next.texture_column = '0;
      end else if (|col_mir[TEX_W-1:COL_W]) begin
        res_next.texture_column = COL_MAX;
      end else begin
        res_next.texture_column = col_mir[COL_W-1:0];
      end
      res_next.texture_step  = (|step5[TNUM_W-1:STEP_W]) ? '1 : step5[STEP_W-1:0];
      res_next.texture_start = (|start_prod5[OFF_W+TNUM_W-1:START_W]) ? '1
                             : start_prod5[START_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res6 <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v4 <= va;
      v5 <= vc;
      v6 <= v5;
    end
  end

  logic    buf_ready;
  result_t out_item;

  assign en        = !v6 || buf_ready;
  assign hit.ready = en;

  rcw_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (v6),
    .push_ready (buf_ready),
    .push_item  (res6),
    .pop_valid  (column.valid),
    .pop_ready  (column.ready),
    .pop_item   (out_item)
  );

  assign column.visible        = out_item.visible;
  assign column.wall_rows      = out_item.wall_rows;
  assign column.row_first      = out_item.row_first;
  assign column.row_last       = out_item.row_last;
  assign column.texture_column = out_item.texture_column;
  assign column.texture_step   = out_item.texture_step;
  assign column.texture_start  = out_item.texture_start;

  a_visible_height: assert property (@(posedge clk) disable iff (rst)
    column.valid && column.visible |-> column.wall_rows != '0)
    else $error("visible column with zero height");

  a_hidden_clear: assert property (@(posedge clk) disable iff (rst)
    column.valid && !column.visible |-> column.wall_rows == '0
      && column.row_first == '0 && column.texture_step == '0 && column.texture_start == '0)
    else $error("hidden column carries nonzero fields");

  a_rows_ordered: assert property (@(posedge clk) disable iff (rst)
    column.valid && column.visible |-> column.row_first <= column.row_last)
    else $error("draw start below draw end");

endmodule

>>> hdl/rcw_divider.sv
module rcw_divider #(
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quo,
  output logic [DEN_W-1:0]  rem,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld [NUM_W];
  logic [NUM_W-1:0]  nq  [NUM_W];
  logic [DEN_W-1:0]  rr  [NUM_W];
  logic [DEN_W-1:0]  dd  [NUM_W];
  logic [SIDE_W-1:0] ss  [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_step
    logic              v_in;
    logic [NUM_W-1:0]  nq_in;
    logic [DEN_W-1:0]  r_in;
    logic [DEN_W-1:0]  d_in;
    logic [SIDE_W-1:0] s_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (i == 0) begin : g_head
      assign v_in  = in_valid;
      assign nq_in = num;
      assign r_in  = '0;
      assign d_in  = den;
      assign s_in  = side_in;
    end else begin : g_body
      assign v_in  = vld[i-1];
      assign nq_in = nq[i-1];
      assign r_in  = rr[i-1];
      assign d_in  = dd[i-1];
      assign s_in  = ss[i-1];
    end

    assign trial = {r_in, nq_in[NUM_W-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq[i] <= {nq_in[NUM_W-2:0], ge};
        rr[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        dd[i] <= d_in;
        ss[i] <= s_in;
      end
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign quo       = nq[NUM_W-1];
  assign rem       = rr[NUM_W-1];
  assign side_out  = ss[NUM_W-1];

endmodule

>>> hdl/rcw_out_buf.sv
module rcw_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  rcw_pkg::result_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output rcw_pkg::result_t pop_item
);
  import rcw_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_item;
  result_t skid_item;
  logic    push;
  logic    pop;

  assign push_ready = !skid_valid;
  assign push       = push_valid && !skid_valid;
  assign pop        = main_valid && pop_ready;
  assign pop_valid  = main_valid;
  assign pop_item   = main_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          skid_valid <= 1'b0;
        end
      end else if (push && main_valid && !pop) begin
        skid_valid <= 1'b1;
      end
      if (!main_valid || pop) begin
        main_valid <= skid_valid || push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_item <= skid_valid ? skid_item : push_item;
    end
    if (!skid_valid && push && main_valid && !pop) begin
      skid_item <= push_item;
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rcw_pkg::*;

  typedef struct {
    logic [POS_W-1:0]        px;
    logic [POS_W-1:0]        py;
    logic [CELL_W-1:0]       cx;
    logic [CELL_W-1:0]       cy;
    logic                    sxn;
    logic                    syn;
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
    logic                    side;
  } wall_hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rcw_hit_if    hit();
  rcw_column_if column();
  rcw_cfg_if    cfg();

  raycast_wall_column_setup uut (
    .clk(clk),
    .rst(rst),
    .hit(hit.sink),
    .column(column.source),
    .cfg(cfg.sink)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  longint  win_h = 480;
  longint  tex_w = 64;
  longint  tex_h = 64;
  result_t columns_due[$];
  int      errors = 0;
  int      burst_left = 0;
  bit      no_gaps = 1'b0;
  int      hold_request = 0;
  int      hold_left = 0;
  int      stall_mode = 0;

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b != 0) && ((a < 0) != (b < 0))) q = q - 1;
    return q;
  endfunction

  function automatic result_t project_column(wall_hit_t h);
    result_t r;
    longint  n, d, e, other, lh, ds, de, w, col, stepv, off, startv, fr;
    r = '0;
    if (!h.side) begin
      n = longint'(h.cx) * 65536 - longint'(h.px) + (h.sxn ? 65536 : 0);
      d = h.dx;
      e = h.dy;
      other = h.py;
    end else begin
      n = longint'(h.cy) * 65536 - longint'(h.py) + (h.syn ? 65536 : 0);
      d = h.dy;
      e = h.dx;
      other = h.px;
    end
    if (d == 0) return r;
    if (n == 0) begin
      if (d < 0) return r;
      lh = 65535;
    end else begin
      lh = (win_h * d) / n;
      if (lh <= 0) return r;
      if (lh > 65535) lh = 65535;
    end
    ds = win_h / 2 - lh / 2;
    if (ds < 0) ds = 0;
    de = lh / 2 + win_h / 2;
    if (de >= win_h) de = (win_h > 0) ? win_h - 1 : 0;
    w = other + floor_quot(n * e, d);
    fr = w & 64'hFFFF;
    if (tex_w == 0) begin
      col = 0;
    end else begin
      col = (fr * tex_w) >>> 16;
      if ((!h.side && d < 0) || (h.side && d > 0)) col = tex_w - col - 1;
      if (col > 1023) col = 1023;
    end
    stepv = (tex_h << 16) / lh;
    off = ds - win_h / 2 + lh / 2;
    startv = off * stepv;
    if (startv > 64'hFFFF_FFFF) startv = 64'hFFFF_FFFF;
    if (stepv > 64'h3FF_FFFF) stepv = 64'h3FF_FFFF;
    r.visible        = 1'b1;
    r.wall_rows      = lh[LH_W-1:0];
    r.row_first      = ds[ROW_W-1:0];
    r.row_last       = de[ROW_W-1:0];
    r.texture_column = col[COL_W-1:0];
    r.texture_step   = stepv[STEP_W-1:0];
    r.texture_start  = startv[START_W-1:0];
    return r;
  endfunction

  task automatic report(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && column.valid && column.ready) begin
      if (columns_due.size() == 0) begin
        $display("%0t: column request with none expected, expected none actual %0d",
                 $time, column.wall_rows);
        errors++;
      end else begin
        want = columns_due.pop_front();
        report("visible", want.visible, column.visible);
        report("wall_rows", want.wall_rows, column.wall_rows);
        report("row_first", want.row_first, column.row_first);
        report("row_last", want.row_last, column.row_last);
        report("texture_column", want.texture_column, column.texture_column);
        report("texture_step", want.texture_step, column.texture_step);
        report("texture_start", want.texture_start, column.texture_start);
      end
    end
    if (hold_left == 0 && hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      column.ready <= 1'b0;
    end else if (stall_mode == 1) begin
      column.ready <= ($urandom_range(0, 3) != 0);
    end else if (stall_mode == 2) begin
      column.ready <= ($urandom_range(0, 2) == 0);
    end else begin
      column.ready <= 1'b1;
    end
  end

  task automatic send_hit(wall_hit_t h);
    if (!no_gaps && burst_left == 0) begin
      hit.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    hit.valid           <= 1'b1;
    hit.player_x        <= h.px;
    hit.player_y        <= h.py;
    hit.cell_x          <= h.cx;
    hit.cell_y          <= h.cy;
    hit.step_x_negative <= h.sxn;
    hit.step_y_negative <= h.syn;
    hit.ray_dir_x       <= h.dx;
    hit.ray_dir_y       <= h.dy;
    hit.hit_side        <= h.side;
    do @(posedge clk); while (!hit.ready);
    columns_due.push_back(project_column(h));
  endtask

  task automatic wait_drained();
    hit.valid <= 1'b0;
    @(posedge clk);
    while (columns_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int value);
    wait_drained();
    repeat (100) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_SCREEN_ROWS:    win_h = value & 12'hFFF;
      REG_TEXTURE_WIDTH:  tex_w = value & 11'h7FF;
      REG_TEXTURE_HEIGHT: tex_h = value & 11'h7FF;
      default: ;
    endcase
  endtask

  task automatic set_view(int wh, int tw, int th);
    write_reg(REG_SCREEN_ROWS, wh);
    write_reg(REG_TEXTURE_WIDTH, tw);
    write_reg(REG_TEXTURE_HEIGHT, th);
  endtask

  function automatic wall_hit_t noise_hit();
    wall_hit_t h;
    h.px = POS_W'($urandom); h.py = POS_W'($urandom);
    h.cx = CELL_W'($urandom); h.cy = CELL_W'($urandom);
    h.sxn = 1'($urandom); h.syn = 1'($urandom);
    h.dx = DIR_W'($urandom); h.dy = DIR_W'($urandom);
    h.side = 1'($urandom);
    return h;
  endfunction

  // A ray that leaves the player's cell and reaches a wall a few cells away.
  function automatic wall_hit_t cast_hit();
    wall_hit_t h;
    int pcx, pcy, k;
    h = noise_hit();
    pcx = int'(h.px[23:16]);
    pcy = int'(h.py[23:16]);
    if ($urandom_range(0, 3) == 0) h.dx = DIR_W'(int'($urandom_range(0, 2047)) - 1024);
    if ($urandom_range(0, 3) == 0) h.dy = DIR_W'(int'($urandom_range(0, 2047)) - 1024);
    h.sxn = h.dx < 0;
    h.syn = h.dy < 0;
    k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 4);
    h.cx = h.sxn ? CELL_W'(pcx - k - 1) : CELL_W'(pcx + k + 1);
    k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 4);
    h.cy = h.syn ? CELL_W'(pcy - k - 1) : CELL_W'(pcy + k + 1);
    return h;
  endfunction

  task automatic send_random(int count);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) send_hit(noise_hit());
      else send_hit(cast_hit());
    end
  endtask

  task automatic test_directed();
    wall_hit_t h;
    h = '{px: 24'h02_8000, py: 24'h03_4000, cx: 8'd5, cy: 8'd7, sxn: 1'b0, syn: 1'b0,
          dx: 18'sd65536, dy: 18'sd30000, side: 1'b0};
    send_hit(h);
    h.side = 1'b1; send_hit(h);
    h.dx = 18'sd0; h.side = 1'b0; send_hit(h);
    h.dy = 18'sd0; h.side = 1'b1; send_hit(h);
    h.dx = 18'sd131071; h.dy = 18'sh20000; h.cy = 8'd0; h.syn = 1'b1; send_hit(h);
    h.side = 1'b0; h.dx = 18'sh20000; h.cx = 8'd1; h.sxn = 1'b1; send_hit(h);
    h.px = 24'h03_0000; h.cx = 8'd3; h.sxn = 1'b0; h.dx = 18'sd4000; send_hit(h);
    h.dx = -18'sd4000; send_hit(h);
    h.py = 24'h04_0000; h.cy = 8'd3; h.syn = 1'b1; h.side = 1'b1;
    h.dy = 18'sd500; send_hit(h);
    h.dy = -18'sd500; send_hit(h);
    h.px = 24'hFF_FFFF; h.py = 24'hFF_FFFF; h.cx = 8'd0; h.cy = 8'd0;
    h.dx = 18'sd131071; h.dy = 18'sd131071; h.side = 1'b0; send_hit(h);
    h.side = 1'b1; send_hit(h);
    h.px = 24'h00_0000; h.py = 24'h00_0000; h.cx = 8'd255; h.cy = 8'd255;
    h.sxn = 1'b1; h.syn = 1'b1; send_hit(h);
    h.side = 1'b0; h.dx = 18'sd1; send_hit(h);
    h.cx = 8'd0; h.sxn = 1'b0; h.dx = 18'sd131071; send_hit(h);
    h.px = 24'h00_0001; send_hit(h);
  endtask

  task automatic test_backpressure();
    hold_request = 300;
    no_gaps = 1'b1;
    send_random(120);
    no_gaps = 1'b0;
    wait_drained();
  endtask

  task automatic test_view(int wh, int tw, int th, int count);
    set_view(wh, tw, th);
    test_directed();
    send_random(count);
  endtask

  initial begin
    hit.valid = 1'b0; hit.player_x = '0; hit.player_y = '0; hit.cell_x = '0;
    hit.cell_y = '0; hit.step_x_negative = 1'b0; hit.step_y_negative = 1'b0;
    hit.ray_dir_x = '0; hit.ray_dir_y = '0; hit.hit_side = 1'b0;
    column.ready = 1'b0;
    cfg.valid = 1'b0; cfg.index = REG_SCREEN_ROWS; cfg.data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_random(20);
    test_backpressure();
    test_view(4095, 1024, 1024, 100);
    test_view(1, 1, 1, 80);
    test_view(0, 0, 0, 60);
    test_view(240, 2047, 2047, 100);
    no_gaps = 1'b1;
    test_view($urandom_range(2, 4094), $urandom_range(2, 1023), $urandom_range(2, 1023), 100);
    no_gaps = 1'b0;
    test_view(600, 256, 16, 80);
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("raycast_wall_column_setup verification clean");
    end else begin
      $display("raycast_wall_column_setup verification failed");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("raycast_wall_column_setup verification failed");
    $finish;
  end

endmodule
